### src/agl_pkg.sv
package agl_pkg;

  // Pin stroke in 1/4096 of full travel
  localparam logic [12:0] PinFull = 13'd4096;
  localparam logic [12:0] PinHalf = 13'd2048;
  localparam logic [12:0] PinZero = 13'd0;

  // Mechanical stops in 1/64 degree, held one bit wider than the angle
  localparam logic signed [15:0] AlphaMax = 16'sd13184;
  localparam logic signed [15:0] AlphaMin = -16'sd9856;
  localparam logic signed [14:0] BetaMax  = 15'sd5440;
  localparam logic signed [14:0] BetaMin  = -15'sd4800;

  // Reset angles
  localparam logic signed [14:0] AlphaReset = 15'sd7955;
  localparam logic signed [13:0] BetaReset  = -14'sd1760;

  // Lock motor commands
  localparam logic [1:0] CmdOff    = 2'd0;
  localparam logic [1:0] CmdLock   = 2'd1;
  localparam logic [1:0] CmdUnlock = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] RegPin1Step  = 2'd0;
  localparam logic [1:0] RegPin2Step  = 2'd1;
  localparam logic [1:0] RegAlphaIdx  = 2'd2;
  localparam logic [1:0] RegBetaIdx   = 2'd3;

  typedef struct packed {
    logic [14:0] alpha_pos;
    logic [13:0] beta_pos;
    logic [12:0] pin1_pos;
    logic [12:0] pin2_pos;
  } gimbal_state_t;

  typedef struct packed {
    logic [12:0] pin1_step;
    logic [12:0] pin2_step;
    logic [14:0] alpha_index;
    logic [13:0] beta_index;
  } gimbal_cfg_t;

endpackage

### src/agl_tick.sv
module agl_tick (
  input  agl_pkg::gimbal_state_t cur,
  input  agl_pkg::gimbal_cfg_t   cfg,
  input  logic [1:0]             lock_command,
  input  logic signed [10:0]     alpha_step,
  input  logic signed [10:0]     beta_step,
  output agl_pkg::gimbal_state_t nxt,
  output logic                   alpha_pulse,
  output logic                   beta_pulse
);
  import agl_pkg::*;

  logic [13:0]        pin1_sum;
  logic [13:0]        pin2_sum;
  logic [12:0]        pin1_up;
  logic [12:0]        pin2_up;
  logic [12:0]        pin1_down;
  logic [12:0]        pin2_down;
  logic [12:0]        pin1_new;
  logic [12:0]        pin2_new;
  logic               free_move;
  logic signed [15:0] alpha_sum;
  logic signed [14:0] beta_sum;
  logic signed [15:0] alpha_clamp;
  logic signed [14:0] beta_clamp;
  logic signed [14:0] alpha_old;
  logic signed [14:0] alpha_new;
  logic signed [14:0] alpha_idx;
  logic signed [13:0] beta_old;
  logic signed [13:0] beta_new;
  logic signed [13:0] beta_idx;

  // Lock travel, clamped at full stroke
  assign pin1_sum  = {1'b0, cur.pin1_pos} + {1'b0, cfg.pin1_step};
  assign pin2_sum  = {1'b0, cur.pin2_pos} + {1'b0, cfg.pin2_step};
  assign pin1_up   = (pin1_sum > {1'b0, PinFull}) ? PinFull : pin1_sum[12:0];
  assign pin2_up   = (pin2_sum > {1'b0, PinFull}) ? PinFull : pin2_sum[12:0];

  // Unlock travel, clamped at zero
  assign pin1_down = (cfg.pin1_step >= cur.pin1_pos) ? PinZero
                                                     : cur.pin1_pos - cfg.pin1_step;
  assign pin2_down = (cfg.pin2_step >= cur.pin2_pos) ? PinZero
                                                     : cur.pin2_pos - cfg.pin2_step;

  always_comb begin
    pin1_new = cur.pin1_pos;
    pin2_new = cur.pin2_pos;
    case (lock_command)
      CmdLock: begin
        // pin 2 drives only once pin 1 is home
        if (cur.pin1_pos < PinFull) begin
          pin1_new = pin1_up;
        end else begin
          pin2_new = pin2_up;
        end
      end
      CmdUnlock: begin
        pin1_new = pin1_down;
        pin2_new = pin2_down;
      end
      default: begin
      end
    endcase
  end

  assign free_move = (pin1_new < PinHalf) || (pin2_new < PinHalf);

  assign alpha_old = $signed(cur.alpha_pos);
  assign beta_old  = $signed(cur.beta_pos);
  assign alpha_idx = $signed(cfg.alpha_index);
  assign beta_idx  = $signed(cfg.beta_index);

  always_comb begin
    alpha_sum = {alpha_old[14], alpha_old};
    beta_sum  = {beta_old[13], beta_old};
    if (free_move) begin
      alpha_sum = {alpha_old[14], alpha_old} + {{5{alpha_step[10]}}, alpha_step};
      beta_sum  = {beta_old[13], beta_old} + {{4{beta_step[10]}}, beta_step};
    end
  end

  assign alpha_clamp = (alpha_sum > AlphaMax) ? AlphaMax :
                       (alpha_sum < AlphaMin) ? AlphaMin : alpha_sum;
  assign beta_clamp  = (beta_sum > BetaMax) ? BetaMax :
                       (beta_sum < BetaMin) ? BetaMin : beta_sum;

  assign alpha_new = alpha_clamp[14:0];
  assign beta_new  = beta_clamp[13:0];

  // Index passed or sitting between old and new angle
  assign alpha_pulse = ((alpha_new >= alpha_idx) && (alpha_idx >= alpha_old)) ||
                       ((alpha_new <= alpha_idx) && (alpha_idx <= alpha_old));
  assign beta_pulse  = ((beta_new >= beta_idx) && (beta_idx >= beta_old)) ||
                       ((beta_new <= beta_idx) && (beta_idx <= beta_old));

  assign nxt.alpha_pos = alpha_new;
  assign nxt.beta_pos  = beta_new;
  assign nxt.pin1_pos  = pin1_new;
  assign nxt.pin2_pos  = pin2_new;

endmodule

### src/antenna_gimbal_lock_model.sv
// Two-axis antenna gimbal with two sequential locking pins, one tick per request.
// Input channel: in_valid / in_stall with lock_command, alpha_step, beta_step.
//   A request is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the new angles, index pulses,
//   stow enable and both pin positions. One result per input request.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write registers only while no request is in flight.
// Flow: the request lands in the input register at the edge that takes it;
//   the tick logic loads the result register and the gimbal state, and
//   out_valid rises, at the edge that fires the request, which a stalled
//   result register delays; the result leaves once out_stall is low.
// Throughput: one request per cycle while out_stall is low; the limit is the
//   state update loop through the pin and angle adders.
// Stall: when out_stall holds a result, the input register keeps the next
//   request and in_stall rises only if that register is also full.
// Reset (rst, synchronous): both channels empty, pins fully locked, alpha at
//   7955 and beta at -1760 in 1/64 degree, step registers 41, index registers 0.
module antenna_gimbal_lock_model (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         lock_command,
  input  logic signed [10:0] alpha_step,
  input  logic signed [10:0] beta_step,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] alpha_angle,
  output logic signed [13:0] beta_angle,
  output logic               alpha_pulse,
  output logic               beta_pulse,
  output logic               stow_enable,
  output logic [12:0]        pin1_position,
  output logic [12:0]        pin2_position,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import agl_pkg::*;

  gimbal_cfg_t   cfg;
  gimbal_state_t state;
  gimbal_state_t state_next;

  // input register
  logic               in_reg_valid;
  logic [1:0]         cmd_reg;
  logic signed [10:0] alpha_step_reg;
  logic signed [10:0] beta_step_reg;

  logic advance;
  logic fire;
  logic alpha_hit;
  logic beta_hit;

  // Result register frees up when empty or being taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin1_step   <= 13'd41;
      cfg.pin2_step   <= 13'd41;
      cfg.alpha_index <= '0;
      cfg.beta_index  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegPin1Step: cfg.pin1_step   <= cfg_data[12:0];
        RegPin2Step: cfg.pin2_step   <= cfg_data[12:0];
        RegAlphaIdx: cfg.alpha_index <= cfg_data;
        RegBetaIdx:  cfg.beta_index  <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // Load the input register whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_reg        <= lock_command;
      alpha_step_reg <= alpha_step;
      beta_step_reg  <= beta_step;
    end
  end

  agl_tick u_tick (
    .cur          (state),
    .cfg          (cfg),
    .lock_command (cmd_reg),
    .alpha_step   (alpha_step_reg),
    .beta_step    (beta_step_reg),
    .nxt          (state_next),
    .alpha_pulse  (alpha_hit),
    .beta_pulse   (beta_hit)
  );

  // Advance the gimbal state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.alpha_pos <= AlphaReset;
      state.beta_pos  <= BetaReset;
      state.pin1_pos  <= PinFull;
      state.pin2_pos  <= PinFull;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      alpha_angle   <= $signed(state_next.alpha_pos);
      beta_angle    <= $signed(state_next.beta_pos);
      alpha_pulse   <= alpha_hit;
      beta_pulse    <= beta_hit;
      stow_enable   <= (state_next.pin2_pos == PinFull);
      pin1_position <= state_next.pin1_pos;
      pin2_position <= state_next.pin2_pos;
    end
  end

`ifndef ASSERT_OFF
  a_pins_in_range: assert property (@(posedge clk) disable iff (rst)
    (state.pin1_pos <= PinFull) && (state.pin2_pos <= PinFull))
    else $error("pin position beyond full stroke");

  a_alpha_in_stops: assert property (@(posedge clk) disable iff (rst)
    ($signed({state.alpha_pos[14], state.alpha_pos}) <= AlphaMax) &&
    ($signed({state.alpha_pos[14], state.alpha_pos}) >= AlphaMin))
    else $error("alpha angle outside mechanical stops");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

  a_state_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("gimbal state changed without a request");

  a_stow_matches_pin2: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stow_enable == (pin2_position == PinFull)))
    else $error("stow enable disagrees with pin 2 position");
`endif

endmodule
